// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge, reset included.
`define AST_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// Implication checked only outside reset.
`define AST_RUN(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/alst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc tessellator package
// Shared constants, the entity descriptor type and small arithmetic helpers.
// ----------------------------------------------------------------------------
package alst_pkg;

  // Angle units per full turn (1/128 degree).
  localparam int ANGLE_TURN = 46080;
  localparam int MAX_SEGS = 64;
  localparam logic [7:0] KEEP_COLOR = 8'd255;
  localparam logic [6:0] SPC_RESET = 7'd64;
  localparam logic signed [31:0] TRIG_GAIN = 32'sd652032874;
  localparam int CORDIC_STEPS_DEF = 18;

  // Field widths.
  localparam int ANG_W = 16;
  localparam int CNT_W = 7;
  localparam int QUO_W = 6;
  localparam int DEN_W = 22;
  localparam int PRD_W = 23;

  // Entity kinds.
  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_ARC = 1'b1;

  // Classified entity handed from the front to the back.
  typedef struct packed {
    logic              kind;
    logic [7:0]        color;
    logic [31:0]       a_x;
    logic [31:0]       a_y;
    logic [31:0]       b_x;
    logic [31:0]       b_y;
    logic [30:0]       radius;
    logic [ANG_W-1:0]  start;
    logic [ANG_W-1:0]  delta;
    logic [CNT_W-1:0]  n;
    logic [DEN_W-1:0]  denom;
  } item_t;

  // Arctangent of 2^-i in phase units (2^32 per turn).
  function automatic logic [31:0] atan_phase(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0: v = 32'h20000000;
      5'd1: v = 32'h12E4051E;
      5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4;
      5'd4: v = 32'h028B0D43;
      5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;
      5'd7: v = 32'h00517C55;
      5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Saturate a signed 64-bit value to 32 bits.
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/alst_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc tessellator front end
// Accepts entities, resolves color and angles and finds the segment count.
// ----------------------------------------------------------------------------
module alst_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [6:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                entity_kind,
  input  logic [7:0]          entity_color,
  input  logic [7:0]          forced_color,
  input  logic signed [31:0]  point_a_x,
  input  logic signed [31:0]  point_a_y,
  input  logic signed [31:0]  point_b_x,
  input  logic signed [31:0]  point_b_y,
  input  logic [30:0]         arc_radius,
  input  logic [15:0]         arc_start_deg,
  input  logic [15:0]         arc_end_deg,
  output logic                item_valid,
  output alst_pkg::item_t     item,
  input  logic                item_ready
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_DEN  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;
  localparam logic [alst_pkg::ANG_W-1:0] TURN16 = alst_pkg::ANG_W'(alst_pkg::ANGLE_TURN);
  localparam logic [6:0] SPC_MAX = 7'(alst_pkg::MAX_SEGS);
  // A full turn is 45 * 1024 units: drop the 1024 by a shift, then divide by
  // 45 through a reciprocal that is exact for every product that can occur.
  localparam int PRE_SHIFT = 10;
  localparam int RECIP_SHIFT = 17;
  localparam int SCL_W = alst_pkg::PRD_W - PRE_SHIFT;
  localparam int RP_W = 25;
  localparam logic [RP_W-1:0] RECIP_45 = RP_W'(2913);

  logic [1:0]                    state;
  logic [6:0]                    spc;
  logic [alst_pkg::PRD_W-1:0]    rem;

  logic [alst_pkg::ANG_W-1:0]    start_r;
  logic [alst_pkg::ANG_W-1:0]    end_r;
  logic [alst_pkg::ANG_W-1:0]    delta_c;
  logic [6:0]                    spc_c;
  logic [SCL_W-1:0]              scaled;
  logic [RP_W-1:0]               recip_prod;
  logic [alst_pkg::QUO_W-1:0]    quo_c;
  logic [alst_pkg::CNT_W-1:0]    n_next;

  assign in_ready   = (state == F_IDLE);
  assign item_valid = (state == F_PUSH);

  // Angle reduction and swept angle.
  always_comb begin
    start_r = (arc_start_deg >= TURN16) ? arc_start_deg - TURN16 : arc_start_deg;
    end_r   = (arc_end_deg >= TURN16) ? arc_end_deg - TURN16 : arc_end_deg;
    if (end_r >= start_r) begin
      delta_c = end_r - start_r;
    end else begin
      delta_c = alst_pkg::ANG_W'(17'(end_r) + 17'(TURN16) - 17'(start_r));
    end
    spc_c = (spc > SPC_MAX) ? SPC_MAX : spc;
  end

  // Quotient of delta * spc by a full turn, from the registered product.
  always_comb begin
    scaled     = rem[alst_pkg::PRD_W-1:PRE_SHIFT];
    recip_prod = RP_W'(scaled) * RECIP_45;
    quo_c      = recip_prod[RECIP_SHIFT +: alst_pkg::QUO_W];
    n_next     = alst_pkg::CNT_W'(quo_c) + 7'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      spc   <= alst_pkg::SPC_RESET;
    end else begin
      if (cfg_wen) begin
        spc <= cfg_wdata;
      end
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            item.kind   <= entity_kind;
            item.color  <= (forced_color != alst_pkg::KEEP_COLOR) ?
                           forced_color : entity_color;
            item.a_x    <= point_a_x;
            item.a_y    <= point_a_y;
            item.b_x    <= point_b_x;
            item.b_y    <= point_b_y;
            item.radius <= arc_radius;
            item.start  <= start_r;
            item.delta  <= delta_c;
            item.n      <= 7'd1;
            item.denom  <= alst_pkg::DEN_W'(alst_pkg::ANGLE_TURN);
            rem         <= alst_pkg::PRD_W'(delta_c) * alst_pkg::PRD_W'(spc_c);
            state       <= (entity_kind == alst_pkg::KIND_ARC) ? F_DIV : F_PUSH;
          end
        end
        F_DIV: begin
          item.n <= n_next;
          state  <= F_DEN;
        end
        F_DEN: begin
          item.denom <= alst_pkg::DEN_W'(item.n) *
                        alst_pkg::DEN_W'(alst_pkg::ANGLE_TURN);
          state      <= F_PUSH;
        end
        F_PUSH: begin
          if (item_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/alst_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc tessellator entity queue
// Two-entry FIFO that decouples the front end from the segment generator.
// ----------------------------------------------------------------------------
module alst_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  alst_pkg::item_t  push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output alst_pkg::item_t  pop_item
);

  alst_pkg::item_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_item;
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/alst_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc tessellator CORDIC
// Iterative rotation giving cosine and sine in Q2.30 for a 32-bit phase.
// ----------------------------------------------------------------------------
module alst_cordic #(
  parameter int STEPS = alst_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         phase,
  output logic                done,
  output logic signed [31:0]  trig_cos,
  output logic signed [31:0]  trig_sin
);

  localparam int IW = $clog2(STEPS);

  logic               busy;
  logic [IW-1:0]      idx;
  logic [1:0]         quad;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [32:0] z;

  logic [31:0]        ph_sum;
  logic [1:0]         quad_c;
  logic [31:0]        resid;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [32:0] at;

  // Quarter-turn reduction of the incoming phase.
  always_comb begin
    ph_sum = phase + 32'h20000000;
    quad_c = ph_sum[31:30];
    resid  = phase - {quad_c, 30'd0};
    dx     = y >>> idx;
    dy     = x >>> idx;
    at     = $signed({1'b0, alst_pkg::atan_phase(5'(idx))});
  end

  // Undo the quarter turns on the final vector.
  always_comb begin
    case (quad)
      2'd0: begin
        trig_cos = x;
        trig_sin = y;
      end
      2'd1: begin
        trig_cos = -y;
        trig_sin = x;
      end
      2'd2: begin
        trig_cos = -x;
        trig_sin = -y;
      end
      default: begin
        trig_cos = y;
        trig_sin = -x;
      end
    endcase
  end

  // One micro-rotation per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
        quad <= quad_c;
        x    <= alst_pkg::TRIG_GAIN;
        y    <= '0;
        z    <= $signed({resid[31], resid});
      end else if (busy) begin
        if (!z[32]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        if (idx == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/alst_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc tessellator segment generator
// Works out point phases, runs the CORDIC, scales and emits each segment.
// ----------------------------------------------------------------------------
module alst_back #(
  parameter int CORDIC_STEPS = alst_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  alst_pkg::item_t     item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  seg_start_x,
  output logic signed [31:0]  seg_start_y,
  output logic signed [31:0]  seg_end_x,
  output logic signed [31:0]  seg_end_y,
  output logic [7:0]          seg_color,
  output logic                seg_last
);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_DIV   = 3'd1;
  localparam logic [2:0] B_CORD  = 3'd2;
  localparam logic [2:0] B_CWAIT = 3'd3;
  localparam logic [2:0] B_MULX  = 3'd4;
  localparam logic [2:0] B_MULY  = 3'd5;
  localparam logic [2:0] B_FIN   = 3'd6;
  localparam logic [2:0] B_OUT   = 3'd7;
  localparam int DW = alst_pkg::DEN_W;

  logic [2:0]                  state;
  logic [7:0]                  color;
  logic signed [31:0]          cx;
  logic signed [31:0]          cy;
  logic [30:0]                 rad;
  logic [alst_pkg::ANG_W-1:0]  delta;
  logic [alst_pkg::CNT_W-1:0]  n_r;
  logic [DW-1:0]               denom;
  logic [DW-1:0]               rem;
  logic [31:0]                 quo;
  logic [4:0]                  dcnt;
  logic                        dsel;
  logic [31:0]                 phase;
  logic [DW-1:0]               acc_rem;
  logic [31:0]                 qd;
  logic [DW-1:0]               rd;
  logic [alst_pkg::CNT_W-1:0]  k;
  logic signed [31:0]          cos_r;
  logic signed [31:0]          sin_r;
  logic signed [63:0]          prod;
  logic signed [31:0]          cur_x;
  logic signed [31:0]          prev_x;
  logic signed [31:0]          prev_y;

  logic                        cordic_done;
  logic signed [31:0]          trig_cos;
  logic signed [31:0]          trig_sin;

  logic [DW:0]                 rem2;
  logic                        ge;
  logic [DW-1:0]               rem_step;
  logic [31:0]                 quo_step;
  logic [DW:0]                 acc_sum;
  logic                        wrap;
  logic [DW-1:0]               acc_rem_next;
  logic [31:0]                 phase_next;
  logic signed [31:0]          mul_a;
  logic signed [31:0]          mul_b;
  logic signed [63:0]          mul_full;
  logic signed [63:0]          rnd;
  logic signed [31:0]          ctr;
  logic [31:0]                 coord;

  assign item_ready = (state == B_IDLE);

  alst_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (state == B_CORD),
    .phase   (phase),
    .done    (cordic_done),
    .trig_cos(trig_cos),
    .trig_sin(trig_sin)
  );

  // Restoring division step: one phase bit per cycle.
  always_comb begin
    rem2     = {rem, 1'b0};
    ge       = (rem2 >= {1'b0, denom});
    rem_step = ge ? DW'(rem2 - {1'b0, denom}) : rem2[DW-1:0];
    quo_step = {quo[30:0], ge};
  end

  // Phase of the next point: exact step of quotient and remainder.
  always_comb begin
    acc_sum      = {1'b0, acc_rem} + {1'b0, rd};
    wrap         = (acc_sum >= {1'b0, denom});
    acc_rem_next = wrap ? DW'(acc_sum - {1'b0, denom}) : acc_sum[DW-1:0];
    phase_next   = phase + qd + {31'd0, wrap};
  end

  // Radius scaling, rounding, centre offset and saturation.
  always_comb begin
    mul_a    = $signed({1'b0, rad});
    mul_b    = (state == B_MULX) ? cos_r : sin_r;
    mul_full = mul_a * mul_b;
    rnd      = (prod + 64'sd536870912) >>> 30;
    ctr      = (state == B_FIN) ? cy : cx;
    coord    = alst_pkg::sat32(rnd + 64'(ctr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (item_valid) begin
            color <= item.color;
            cx    <= item.a_x;
            cy    <= item.a_y;
            rad   <= item.radius;
            delta <= item.delta;
            n_r   <= item.n;
            denom <= item.denom;
            if (item.kind == alst_pkg::KIND_LINE) begin
              seg_start_x <= item.a_x;
              seg_start_y <= item.a_y;
              seg_end_x   <= item.b_x;
              seg_end_y   <= item.b_y;
              seg_color   <= item.color;
              seg_last    <= 1'b1;
              out_valid   <= 1'b1;
              state       <= B_OUT;
            end else begin
              rem   <= DW'(item.start) * DW'(item.n);
              quo   <= '0;
              dcnt  <= '0;
              dsel  <= 1'b0;
              state <= B_DIV;
            end
          end
        end
        B_DIV: begin
          rem  <= rem_step;
          quo  <= quo_step;
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd31) begin
            if (!dsel) begin
              phase   <= quo_step;
              acc_rem <= rem_step;
              rem     <= DW'(delta);
              quo     <= '0;
              dsel    <= 1'b1;
            end else begin
              qd    <= quo_step;
              rd    <= rem_step;
              k     <= '0;
              state <= B_CORD;
            end
          end
        end
        B_CORD: begin
          state <= B_CWAIT;
        end
        B_CWAIT: begin
          if (cordic_done) begin
            cos_r <= trig_cos;
            sin_r <= trig_sin;
            state <= B_MULX;
          end
        end
        B_MULX: begin
          prod  <= mul_full;
          state <= B_MULY;
        end
        B_MULY: begin
          cur_x <= coord;
          prod  <= mul_full;
          state <= B_FIN;
        end
        B_FIN: begin
          prev_x  <= cur_x;
          prev_y  <= coord;
          phase   <= phase_next;
          acc_rem <= acc_rem_next;
          k       <= k + 7'd1;
          if (k == '0) begin
            state <= B_CORD;
          end else begin
            seg_start_x <= prev_x;
            seg_start_y <= prev_y;
            seg_end_x   <= cur_x;
            seg_end_y   <= coord;
            seg_color   <= color;
            seg_last    <= (k == n_r);
            out_valid   <= 1'b1;
            state       <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= seg_last ? B_IDLE : B_CORD;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/arc_line_segment_tessellator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc and line segment tessellator
// Turns line and arc entities into straight segments; arcs use CORDIC.
// ----------------------------------------------------------------------------
//   Channel   Handshake              Moves
//   cfg       cfg_wen                segments_per_circle write, no wait
//   in        in_valid / in_ready    one entity per transaction
//   out       out_valid / out_ready  one segment per transaction
//
// A line passes the front end and the queue and leaves straight from the
// segment generator. An arc is classified and queued, then runs two 32-step
// phase divisions, then computes n + 1 points, each through the iterative
// CORDIC and the shared multiplier. A two-entry queue lets new
// entities be taken while segments wait on out_ready. Reset clears all
// control state.
// ----------------------------------------------------------------------------
module arc_line_segment_tessellator #(
  parameter int CORDIC_STEPS = alst_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [6:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                entity_kind,
  input  logic [7:0]          entity_color,
  input  logic [7:0]          forced_color,
  input  logic signed [31:0]  point_a_x,
  input  logic signed [31:0]  point_a_y,
  input  logic signed [31:0]  point_b_x,
  input  logic signed [31:0]  point_b_y,
  input  logic [30:0]         arc_radius,
  input  logic [15:0]         arc_start_deg,
  input  logic [15:0]         arc_end_deg,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  seg_start_x,
  output logic signed [31:0]  seg_start_y,
  output logic signed [31:0]  seg_end_x,
  output logic signed [31:0]  seg_end_y,
  output logic [7:0]          seg_color,
  output logic                seg_last
);

  logic            fq_valid;
  logic            fq_ready;
  alst_pkg::item_t fq_item;
  logic            qb_valid;
  logic            qb_ready;
  alst_pkg::item_t qb_item;

  // Entity intake and classification.
  alst_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .entity_kind   (entity_kind),
    .entity_color  (entity_color),
    .forced_color  (forced_color),
    .point_a_x     (point_a_x),
    .point_a_y     (point_a_y),
    .point_b_x     (point_b_x),
    .point_b_y     (point_b_y),
    .arc_radius    (arc_radius),
    .arc_start_deg (arc_start_deg),
    .arc_end_deg   (arc_end_deg),
    .item_valid    (fq_valid),
    .item          (fq_item),
    .item_ready    (fq_ready)
  );

  // Decoupling queue.
  alst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_item (fq_item),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_item  (qb_item)
  );

  // Segment generation.
  alst_back #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (qb_valid),
    .item_ready (qb_ready),
    .item       (qb_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .seg_start_x(seg_start_x),
    .seg_start_y(seg_start_y),
    .seg_end_x  (seg_end_x),
    .seg_end_y  (seg_end_y),
    .seg_color  (seg_color),
    .seg_last   (seg_last)
  );

endmodule

// ----- rtl/alst_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc tessellator port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alst_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [31:0]  seg_start_x,
  input logic signed [31:0]  seg_end_y,
  input logic                seg_last
);

  // Reset leaves no segment on offer.
  `AST_ALWAYS(a_rst_idle, clk, rst, !out_valid, "out_valid after reset")

  // A stalled segment stays on offer unchanged.
  `AST_RUN(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(seg_start_x) && $stable(seg_end_y) && $stable(seg_last), "stalled segment changed")

  // The front end drops in_ready in the cycle after each accepted entity.
  `AST_RUN(a_in_busy, clk, rst, in_valid && in_ready, !in_ready, "in_ready held after accept")

  // The next segment always takes computation cycles.
  `AST_RUN(a_out_gap, clk, rst, out_valid && out_ready, !out_valid, "segment back to back")

endmodule

bind arc_line_segment_tessellator alst_checker u_alst_checker (.*);

// ----- tb/arc_line_segment_tessellator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc and line segment tessellator testbench
// Sends line and arc entities under several segment counts and idling
// patterns, predicts every segment with a bit-exact CORDIC model, and
// compares each output transaction with the oldest predicted segment.
// ----------------------------------------------------------------------------
module arc_line_segment_tessellator_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TRIG_STEPS = alst_pkg::CORDIC_STEPS_DEF;
  localparam int DRAIN_CYCLES = 40;

  // Arctangent of 2^-i, 2^32 phase units per turn.
  localparam logic [31:0] ARCTAN_TABLE [0:29] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [7:0]  color;
    logic        last;
  } segment_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [6:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic entity_kind = 1'b0;
  logic [7:0] entity_color = '0;
  logic [7:0] forced_color = '0;
  logic signed [31:0] point_a_x = '0;
  logic signed [31:0] point_a_y = '0;
  logic signed [31:0] point_b_x = '0;
  logic signed [31:0] point_b_y = '0;
  logic [30:0] arc_radius = '0;
  logic [15:0] arc_start_deg = '0;
  logic [15:0] arc_end_deg = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
  logic [7:0] seg_color;
  logic seg_last;

  segment_t pending_segments[$];
  logic [6:0] segs_per_circle = alst_pkg::SPC_RESET;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  arc_line_segment_tessellator dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .entity_kind(entity_kind),
    .entity_color(entity_color), .forced_color(forced_color),
    .point_a_x(point_a_x), .point_a_y(point_a_y), .point_b_x(point_b_x),
    .point_b_y(point_b_y), .arc_radius(arc_radius),
    .arc_start_deg(arc_start_deg), .arc_end_deg(arc_end_deg),
    .out_valid(out_valid), .out_ready(out_ready), .seg_start_x(seg_start_x),
    .seg_start_y(seg_start_y), .seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
    .seg_color(seg_color), .seg_last(seg_last)
  );

  // Clock generation, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp a wide signed value to 32 bits.
  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Cosine and sine in Q2.30 for a phase of 2^32 units per turn.
  function automatic void cordic_trig(input logic [31:0] phase,
                                      output longint cos_v, output longint sin_v);
    logic [31:0] quad;
    logic [31:0] resid;
    longint x, y, z, dx, dy;
    quad = ((phase + 32'h20000000) >> 30) & 32'd3;
    resid = phase - (quad << 30);
    z = longint'(signed'(resid));
    x = longint'(alst_pkg::TRIG_GAIN);
    y = 0;
    for (int i = 0; i < TRIG_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ARCTAN_TABLE[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ARCTAN_TABLE[i]);
      end
    end
    case (quad)
      32'd0: begin cos_v = x; sin_v = y; end
      32'd1: begin cos_v = -y; sin_v = x; end
      32'd2: begin cos_v = -x; sin_v = -y; end
      default: begin cos_v = y; sin_v = -x; end
    endcase
  endfunction

  // One point on the circle, rounded half up and saturated.
  function automatic void circle_point(input longint cx, input longint cy,
                                       input longint rad, input logic [31:0] phase,
                                       output logic [31:0] px, output logic [31:0] py);
    longint c, s;
    cordic_trig(phase, c, s);
    px = clamp32(cx + ((rad * c + (64'sd1 <<< 29)) >>> 30));
    py = clamp32(cy + ((rad * s + (64'sd1 <<< 29)) >>> 30));
  endfunction

  // Predict the segments of the entity currently on the input ports.
  function automatic void predict_segments();
    segment_t seg;
    longint unsigned start_a, end_a, sweep, nseg, spc, denom, num;
    logic [31:0] px, py;
    seg.color = (forced_color != alst_pkg::KEEP_COLOR) ? forced_color : entity_color;
    if (entity_kind == alst_pkg::KIND_LINE) begin
      seg.sx = point_a_x; seg.sy = point_a_y;
      seg.ex = point_b_x; seg.ey = point_b_y;
      seg.last = 1'b1;
      pending_segments.push_back(seg);
      return;
    end
    start_a = arc_start_deg;
    end_a = arc_end_deg;
    if (start_a >= alst_pkg::ANGLE_TURN) start_a -= alst_pkg::ANGLE_TURN;
    if (end_a >= alst_pkg::ANGLE_TURN) end_a -= alst_pkg::ANGLE_TURN;
    sweep = (end_a >= start_a) ? end_a - start_a : end_a + alst_pkg::ANGLE_TURN - start_a;
    spc = (segs_per_circle > alst_pkg::MAX_SEGS) ? alst_pkg::MAX_SEGS : segs_per_circle;
    nseg = 1 + (sweep * spc) / alst_pkg::ANGLE_TURN;
    if (nseg > alst_pkg::MAX_SEGS) nseg = alst_pkg::MAX_SEGS;
    denom = alst_pkg::ANGLE_TURN * nseg;
    circle_point(point_a_x, point_a_y, arc_radius,
                 32'(((start_a * nseg) << 32) / denom), px, py);
    for (longint unsigned k = 0; k < nseg; k++) begin
      seg.sx = px; seg.sy = py;
      num = start_a * nseg + sweep * (k + 1);
      circle_point(point_a_x, point_a_y, arc_radius, 32'((num << 32) / denom), px, py);
      seg.ex = px; seg.ey = py;
      seg.last = (k + 1 == nseg);
      pending_segments.push_back(seg);
    end
  endfunction

  // Output side: random stalls, checking and the watchdog.
  always @(posedge clk) begin
    segment_t want;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_segments.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected segment transaction at %0t", $realtime);
      end else begin
        want = pending_segments.pop_front();
        if (want.sx !== seg_start_x || want.sy !== seg_start_y ||
            want.ex !== seg_end_x || want.ey !== seg_end_y ||
            want.color !== seg_color || want.last !== seg_last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Segment differs: exp %h %h %h %h c%0d l%0d got %h %h %h %h c%0d l%0d",
                     want.sx, want.sy, want.ex, want.ey, want.color, want.last,
                     seg_start_x, seg_start_y, seg_end_x, seg_end_y, seg_color,
                     seg_last);
        end
      end
    end
  end

  // Send one entity; valid stays high until the transaction completes.
  task automatic send_entity(input logic kind, input logic [7:0] ecol,
                             input logic [7:0] ocol, input logic [31:0] ax,
                             input logic [31:0] ay, input logic [31:0] bx,
                             input logic [31:0] by, input logic [30:0] rad,
                             input logic [15:0] sdeg, input logic [15:0] edeg);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    entity_kind <= kind; entity_color <= ecol; forced_color <= ocol;
    point_a_x <= ax; point_a_y <= ay; point_b_x <= bx; point_b_y <= by;
    arc_radius <= rad; arc_start_deg <= sdeg; arc_end_deg <= edeg;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_segments();
  endtask

  // Stop sending and wait until every predicted segment has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_segments.size() != 0) @(posedge clk);
  endtask

  // Write the segment count while the block is idle.
  task automatic write_segs_per_circle(input logic [6:0] value);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    segs_per_circle = value;
  endtask

  // Random arc with a mix of small, large and unreduced values.
  task automatic send_random_arc();
    logic [30:0] rad;
    logic [15:0] sdeg, edeg;
    case ($urandom_range(3))
      0: rad = 31'($urandom_range(1 << 20));
      1: rad = 31'($urandom);
      2: rad = 31'h7FFFFFFF;
      default: rad = 31'd0;
    endcase
    sdeg = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(46079));
    edeg = ($urandom_range(9) == 0) ? sdeg : 16'($urandom_range(46079));
    if ($urandom_range(9) == 0) edeg = 16'($urandom);
    send_entity(alst_pkg::KIND_ARC, 8'($urandom),
                ($urandom_range(1) ? 8'hFF : 8'($urandom)),
                $urandom, $urandom, $urandom, $urandom, rad, sdeg, edeg);
  endtask

  // Lines with extreme coordinates and both colour paths.
  task automatic test_lines();
    send_entity(alst_pkg::KIND_LINE, 8'd0, 8'hFF, 32'h80000000, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 16'hFFFF, 16'h0);
    send_entity(alst_pkg::KIND_LINE, 8'hFF, 8'd0, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h0,
                31'h0, 16'h0, 16'hFFFF);
    send_entity(alst_pkg::KIND_LINE, 8'hA5, 8'hFE, $urandom, $urandom, $urandom,
                $urandom, 31'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Arc corner cases at the reset segment count.
  task automatic test_arc_corners();
    send_entity(alst_pkg::KIND_ARC, 8'd3, 8'hFF, 32'h0, 32'h0, 32'h0, 32'h0,
                31'h00010000, 16'd0, 16'd46079);
    send_entity(alst_pkg::KIND_ARC, 8'd4, 8'd9, 32'h00100000, 32'hFFF00000, $urandom,
                $urandom, 31'h00020000, 16'd11520, 16'd11520);
    send_entity(alst_pkg::KIND_ARC, 8'd5, 8'hFF, 32'h7FFF0000, 32'h80010000, 32'h0,
                32'h0, 31'h7FFFFFFF, 16'd40000, 16'd5000);
    send_entity(alst_pkg::KIND_ARC, 8'd6, 8'hFF, 32'h12345678, 32'h0, 32'h0, 32'h0,
                31'h0, 16'd1000, 16'd30000);
    send_entity(alst_pkg::KIND_ARC, 8'd7, 8'hFF, 32'h0, 32'h0, 32'h0, 32'h0,
                31'h01000000, 16'hFFFF, 16'd46080);
    // Hold back until the block is empty before the next arc.
    drain();
    send_entity(alst_pkg::KIND_ARC, 8'd8, 8'hFF, 32'h80000000, 32'h80000000, 32'h0,
                32'h0, 31'h7FFFFFFF, 16'd23040, 16'd0);
  endtask

  // Segment count extremes, including zero and values above the maximum.
  task automatic test_segment_counts();
    write_segs_per_circle(7'd1);
    send_entity(alst_pkg::KIND_ARC, 8'd1, 8'hFF, 32'h0, 32'h0, 32'h0, 32'h0,
                31'h00080000, 16'd100, 16'd99);
    write_segs_per_circle(7'd0);
    send_entity(alst_pkg::KIND_ARC, 8'd2, 8'hFF, 32'h0, 32'h0, 32'h0, 32'h0,
                31'h00080000, 16'd0, 16'd46079);
    write_segs_per_circle(7'd127);
    send_entity(alst_pkg::KIND_ARC, 8'd3, 8'hFF, 32'h0, 32'h0, 32'h0, 32'h0,
                31'h00080000, 16'd5, 16'd4);
    write_segs_per_circle(7'd65);
    send_entity(alst_pkg::KIND_ARC, 8'd4, 8'hFF, 32'h0, 32'h0, 32'h0, 32'h0,
                31'h00080000, 16'd0, 16'd23040);
  endtask

  // Random traffic through four idling patterns and several segment counts.
  task automatic test_random_traffic();
    int pattern_send [4] = '{0, 55, 0, 10};
    int pattern_recv [4] = '{0, 0, 55, 10};
    logic [6:0] counts [4] = '{7'd8, 7'd64, 7'd3, 7'd20};
    for (int p = 0; p < 4; p++) begin
      write_segs_per_circle(counts[p]);
      send_idle_pct = pattern_send[p];
      recv_stall_pct = pattern_recv[p];
      for (int i = 0; i < 26; i++) begin
        if ($urandom_range(2) == 0)
          send_entity(alst_pkg::KIND_LINE, 8'($urandom),
                      ($urandom_range(1) ? 8'hFF : 8'($urandom)),
                      $urandom, $urandom, $urandom, $urandom, 31'($urandom),
                      16'($urandom), 16'($urandom));
        else
          send_random_arc();
      end
    end
    write_segs_per_circle(7'($urandom_range(1, 64)));
    send_idle_pct = 30;
    recv_stall_pct = 30;
    for (int i = 0; i < 26; i++) send_random_arc();
  endtask

  // Test sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_lines();
    test_arc_corners();
    test_segment_counts();
    test_random_traffic();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_segments.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/alst_pkg.sv
rtl/alst_front.sv
rtl/alst_queue.sv
rtl/alst_cordic.sv
rtl/alst_back.sv
rtl/arc_line_segment_tessellator.sv
rtl/alst_checker.sv
tb/arc_line_segment_tessellator_test.sv
